// ===== src/tblm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblm_pkg
// Shared types, constants and helper functions for the three-band level meter.
// ----------------------------------------------------------------------------
package tblm_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int MAG_BITS      = 17;
  localparam int LEVEL_BITS    = 13;
  localparam int SEQ_BITS      = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int MEAN_CAP_BITS = 21;
  localparam int PROD_BITS     = MEAN_CAP_BITS + LEVEL_BITS;
  localparam int SCALE_SHIFT   = 15;
  localparam int SHIFTED_BITS  = PROD_BITS - SCALE_SHIFT;

  localparam logic [MEAN_CAP_BITS-1:0] MEAN_CAP  = 21'h100000;
  localparam logic [LEVEL_BITS-1:0]    LEVEL_MAX = 13'd4096;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_PUBLISH = 1'b1;

  typedef logic [1:0] band_t;
  localparam band_t BAND_TOTAL = 2'd0;
  localparam band_t BAND_LOW   = 2'd1;
  localparam band_t BAND_MID   = 2'd2;
  localparam band_t BAND_HIGH  = 2'd3;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          stopping;
  } tblm_item_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0]   sequence_res;
    logic                  running;
    logic [LEVEL_BITS-1:0] overall_level;
    logic [LEVEL_BITS-1:0] low_level;
    logic [LEVEL_BITS-1:0] mid_level;
    logic [LEVEL_BITS-1:0] high_level;
  } tblm_result_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                kind;
    logic                stopping;
    logic [MAG_BITS-1:0] mag_total;
    logic [MAG_BITS-1:0] mag_low;
    logic [MAG_BITS-1:0] mag_mid;
    logic [MAG_BITS-1:0] mag_high;
  } tblm_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tblm_qstat_t;

  function automatic logic [MAG_BITS-1:0] magnitude(input logic signed [MAG_BITS-1:0] v);
    return v[MAG_BITS-1] ? MAG_BITS'(-v) : MAG_BITS'(v);
  endfunction

  function automatic logic [LEVEL_BITS-1:0] level_scale(input band_t band);
    logic [LEVEL_BITS-1:0] s;
    case (band)
      BAND_TOTAL: s = 13'd1024;
      BAND_LOW:   s = 13'd1536;
      BAND_MID:   s = 13'd4096;
      BAND_HIGH:  s = 13'd3072;
      default:    s = 13'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/tblm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblm_front
// Accepts items, runs the slow and fast one-pole averages and turns each
// item into band magnitudes for the accumulation side.
// ----------------------------------------------------------------------------
module tblm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tblm_pkg::tblm_item_t  in_item,
  output logic                  push,
  output tblm_pkg::tblm_op_t    push_op,
  input  tblm_pkg::tblm_qstat_t q_stat
);

  logic signed [tblm_pkg::SAMPLE_BITS-1:0] slow_r, fast_r, prev_r;
  logic signed [tblm_pkg::SAMPLE_BITS-1:0] slow_nxt, fast_nxt;

  logic                                    p_valid_r;
  logic                                    p_kind_r;
  logic                                    p_stop_r;
  logic signed [tblm_pkg::SAMPLE_BITS-1:0] p_s_r, p_slow_r, p_fast_r, p_prev_r;

  logic signed [tblm_pkg::MAG_BITS-1:0] s_ext, slow_ext, fast_ext;
  logic signed [tblm_pkg::MAG_BITS-1:0] d_slow, d_slow_adj, step_slow, slow_sum;
  logic signed [tblm_pkg::MAG_BITS-1:0] d_fast, d_fast_adj, step_fast, fast_sum;

  logic signed [tblm_pkg::MAG_BITS-1:0] e_s, e_slow, e_fast, e_prev;
  logic signed [tblm_pkg::MAG_BITS-1:0] mid_d, high_d, diff_d;
  logic [tblm_pkg::MAG_BITS:0]          hsum;

  logic accept;

  assign in_stall = p_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = p_valid_r && !q_stat.full;

  // averages, division truncating toward zero
  always_comb begin
    s_ext      = {in_item.sample[tblm_pkg::SAMPLE_BITS-1], in_item.sample};
    slow_ext   = {slow_r[tblm_pkg::SAMPLE_BITS-1], slow_r};
    fast_ext   = {fast_r[tblm_pkg::SAMPLE_BITS-1], fast_r};
    d_slow     = s_ext - slow_ext;
    d_slow_adj = d_slow + (d_slow[tblm_pkg::MAG_BITS-1] ? 17'sd15 : 17'sd0);
    step_slow  = d_slow_adj >>> 4;
    slow_sum   = slow_ext + step_slow;
    slow_nxt   = slow_sum[tblm_pkg::SAMPLE_BITS-1:0];
    d_fast     = s_ext - fast_ext;
    d_fast_adj = d_fast + (d_fast[tblm_pkg::MAG_BITS-1] ? 17'sd3 : 17'sd0);
    step_fast  = d_fast_adj >>> 2;
    fast_sum   = fast_ext + step_fast;
    fast_nxt   = fast_sum[tblm_pkg::SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_r    <= '0;
      fast_r    <= '0;
      prev_r    <= '0;
      p_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        p_valid_r <= 1'b1;
        if (in_item.kind == tblm_pkg::KIND_SAMPLE) begin
          slow_r <= slow_nxt;
          fast_r <= fast_nxt;
          prev_r <= in_item.sample;
        end
      end else if (push) begin
        p_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_kind_r <= in_item.kind;
      p_stop_r <= in_item.stopping;
      p_s_r    <= in_item.sample;
      p_slow_r <= slow_nxt;
      p_fast_r <= fast_nxt;
      p_prev_r <= prev_r;
    end
  end

  // band magnitudes
  always_comb begin
    e_s    = {p_s_r[tblm_pkg::SAMPLE_BITS-1], p_s_r};
    e_slow = {p_slow_r[tblm_pkg::SAMPLE_BITS-1], p_slow_r};
    e_fast = {p_fast_r[tblm_pkg::SAMPLE_BITS-1], p_fast_r};
    e_prev = {p_prev_r[tblm_pkg::SAMPLE_BITS-1], p_prev_r};
    mid_d  = e_fast - e_slow;
    high_d = e_s - e_fast;
    diff_d = e_s - e_prev;
    hsum   = {1'b0, tblm_pkg::magnitude(high_d)} + {1'b0, tblm_pkg::magnitude(diff_d)};
    push_op.kind      = p_kind_r;
    push_op.stopping  = p_stop_r;
    push_op.mag_total = tblm_pkg::magnitude(e_s);
    push_op.mag_low   = tblm_pkg::magnitude(e_slow);
    push_op.mag_mid   = tblm_pkg::magnitude(mid_d);
    push_op.mag_high  = hsum[tblm_pkg::MAG_BITS:1];
  end

endmodule

// ===== src/tblm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblm_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module tblm_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tblm_pkg::tblm_op_t    push_op,
  input  logic                  pop,
  output tblm_pkg::tblm_op_t    pop_op,
  output tblm_pkg::tblm_qstat_t q_stat
);

  tblm_pkg::tblm_op_t                 entries_r [tblm_pkg::QUEUE_DEPTH];
  logic [tblm_pkg::QPTR_BITS-1:0]     wr_ptr_r, rd_ptr_r;
  logic [tblm_pkg::QPTR_BITS:0]       fill_r;

  assign pop_op       = entries_r[rd_ptr_r];
  assign q_stat.full  = (fill_r == (tblm_pkg::QPTR_BITS+1)'(tblm_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (fill_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + tblm_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + tblm_pkg::QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + (tblm_pkg::QPTR_BITS+1)'(1);
        2'b01:   fill_r <= fill_r - (tblm_pkg::QPTR_BITS+1)'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== src/tblm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tblm_back
// Accumulates band magnitudes; a publish with samples and no stopping divides
// each sum by the sample count in a shared bit-serial divider and scales it.
// ----------------------------------------------------------------------------
module tblm_back #(
  parameter int SUM_BITS   = 40,
  parameter int COUNT_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tblm_pkg::tblm_qstat_t  q_stat,
  output logic                   pop,
  input  tblm_pkg::tblm_op_t     pop_op,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tblm_pkg::tblm_result_t out_result
);

  localparam int STEP_BITS = $clog2(SUM_BITS);

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_DIV = 3'b010,
    ST_LVL = 3'b100
  } state_t;

  state_t                          state_r;
  logic [SUM_BITS-1:0]             total_r, low_r, mid_r, high_r;
  logic [COUNT_BITS-1:0]           count_r;
  logic [tblm_pkg::SEQ_BITS-1:0]   seq_r, seq_nxt;
  tblm_pkg::band_t                 band_r, band_nxt;
  logic [STEP_BITS-1:0]            step_r;
  logic [SUM_BITS-1:0]             quo_r;
  logic [COUNT_BITS-1:0]           rem_r;
  logic                            out_valid_r;
  tblm_pkg::tblm_result_t          out_r;

  logic                            out_free;
  logic                            report_done;
  logic [COUNT_BITS:0]             div_tmp, div_cnt, div_sub;
  logic                            div_ge;
  logic [COUNT_BITS-1:0]           rem_nxt;
  logic [SUM_BITS-1:0]             next_sum;
  logic [tblm_pkg::MEAN_CAP_BITS-1:0] mean_cap;
  logic [tblm_pkg::PROD_BITS-1:0]     prod;
  logic [tblm_pkg::SHIFTED_BITS-1:0]  shifted;
  logic [tblm_pkg::LEVEL_BITS-1:0]    level;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] acc,
                                                   input logic [tblm_pkg::MAG_BITS-1:0] add);
    logic [SUM_BITS:0] t;
    t = {1'b0, acc} + (SUM_BITS+1)'(add);
    return t[SUM_BITS] ? {SUM_BITS{1'b1}} : t[SUM_BITS-1:0];
  endfunction

  assign out_valid  = out_valid_r;
  assign out_result = out_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign pop        = !q_stat.empty && (state_r == ST_RUN) &&
                      (pop_op.kind == tblm_pkg::KIND_SAMPLE || out_free);
  assign seq_nxt    = seq_r + tblm_pkg::SEQ_BITS'(1);
  assign band_nxt   = band_r + 2'd1;

  // report finished this cycle
  assign report_done = ((state_r == ST_RUN) && pop &&
                        (pop_op.kind == tblm_pkg::KIND_PUBLISH) &&
                        (pop_op.stopping || count_r == '0)) ||
                       ((state_r == ST_LVL) && (band_r == tblm_pkg::BAND_HIGH));

  // restoring division step
  always_comb begin
    div_tmp = {rem_r, quo_r[SUM_BITS-1]};
    div_cnt = {1'b0, count_r};
    div_sub = div_tmp - div_cnt;
    div_ge  = (div_tmp >= div_cnt);
    rem_nxt = div_ge ? div_sub[COUNT_BITS-1:0] : div_tmp[COUNT_BITS-1:0];
  end

  always_comb begin
    case (band_nxt)
      tblm_pkg::BAND_TOTAL: next_sum = total_r;
      tblm_pkg::BAND_LOW:   next_sum = low_r;
      tblm_pkg::BAND_MID:   next_sum = mid_r;
      tblm_pkg::BAND_HIGH:  next_sum = high_r;
      default:              next_sum = total_r;
    endcase
  end

  // capped mean times scale over 32768, clamped
  always_comb begin
    mean_cap = (quo_r > SUM_BITS'(tblm_pkg::MEAN_CAP)) ? tblm_pkg::MEAN_CAP
                                                        : quo_r[tblm_pkg::MEAN_CAP_BITS-1:0];
    prod     = tblm_pkg::PROD_BITS'(mean_cap) *
               tblm_pkg::PROD_BITS'(tblm_pkg::level_scale(band_r));
    shifted  = prod[tblm_pkg::PROD_BITS-1:tblm_pkg::SCALE_SHIFT];
    level    = (shifted > tblm_pkg::SHIFTED_BITS'(tblm_pkg::LEVEL_MAX)) ?
               tblm_pkg::LEVEL_MAX : shifted[tblm_pkg::LEVEL_BITS-1:0];
  end

  // control and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      total_r     <= '0;
      low_r       <= '0;
      mid_r       <= '0;
      high_r      <= '0;
      count_r     <= '0;
      seq_r       <= '0;
      band_r      <= tblm_pkg::BAND_TOTAL;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (report_done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_RUN: begin
          if (pop) begin
            if (pop_op.kind == tblm_pkg::KIND_SAMPLE) begin
              total_r <= sat_add(total_r, pop_op.mag_total);
              low_r   <= sat_add(low_r, pop_op.mag_low);
              mid_r   <= sat_add(mid_r, pop_op.mag_mid);
              high_r  <= sat_add(high_r, pop_op.mag_high);
              if (count_r != {COUNT_BITS{1'b1}}) begin
                count_r <= count_r + COUNT_BITS'(1);
              end
            end else begin
              seq_r <= seq_nxt;
              if (pop_op.stopping || count_r == '0) begin
                total_r     <= '0;
                low_r       <= '0;
                mid_r       <= '0;
                high_r      <= '0;
                count_r     <= '0;
              end else begin
                band_r  <= tblm_pkg::BAND_TOTAL;
                step_r  <= '0;
                state_r <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          step_r <= step_r + STEP_BITS'(1);
          if (step_r == STEP_BITS'(SUM_BITS - 1)) begin
            state_r <= ST_LVL;
          end
        end
        ST_LVL: begin
          if (band_r == tblm_pkg::BAND_HIGH) begin
            total_r     <= '0;
            low_r       <= '0;
            mid_r       <= '0;
            high_r      <= '0;
            count_r     <= '0;
            state_r     <= ST_RUN;
          end else begin
            band_r  <= band_nxt;
            step_r  <= '0;
            state_r <= ST_DIV;
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  // divider datapath and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      ST_RUN: begin
        if (pop && pop_op.kind == tblm_pkg::KIND_PUBLISH) begin
          out_r.sequence_res  <= seq_nxt;
          out_r.running       <= !pop_op.stopping;
          out_r.overall_level <= '0;
          out_r.low_level     <= '0;
          out_r.mid_level     <= '0;
          out_r.high_level    <= '0;
          quo_r               <= total_r;
          rem_r               <= '0;
        end
      end
      ST_DIV: begin
        quo_r <= {quo_r[SUM_BITS-2:0], div_ge};
        rem_r <= rem_nxt;
      end
      ST_LVL: begin
        case (band_r)
          tblm_pkg::BAND_TOTAL: out_r.overall_level <= level;
          tblm_pkg::BAND_LOW:   out_r.low_level     <= level;
          tblm_pkg::BAND_MID:   out_r.mid_level     <= level;
          tblm_pkg::BAND_HIGH:  out_r.high_level    <= level;
          default:              out_r.overall_level <= level;
        endcase
        quo_r <= next_sum;
        rem_r <= '0;
      end
      default: rem_r <= '0;
    endcase
  end

endmodule

// ===== src/three_band_level_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_band_level_meter
// Three-band audio level meter: filter front, item queue, accumulate and
// publish back.
// ----------------------------------------------------------------------------
// Sample items are taken one per clock while in_stall is low: the front
// registers each sample and its slow and fast averages, a four-entry queue
// decouples it from the back, and the back adds the band magnitudes into
// saturating sums one item per clock while not publishing. A publish item
// with no samples, or with stopping set, yields its result in the cycle
// after the back takes it. Otherwise the back divides the four sums by the
// count in one shared restoring divider at one quotient bit per clock, while
// samples wait in the queue and then at in_stall. The finished report sits
// in an output register, so accumulation carries on while it waits on
// out_stall; a further publish waits until that register is free.
// ----------------------------------------------------------------------------
module three_band_level_meter #(
  parameter int SUM_BITS   = 40,
  parameter int COUNT_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tblm_pkg::tblm_item_t   in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tblm_pkg::tblm_result_t out_result
);

  logic                  push, pop;
  tblm_pkg::tblm_op_t    push_op, pop_op;
  tblm_pkg::tblm_qstat_t q_stat;

  tblm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .push_op  (push_op),
    .q_stat   (q_stat)
  );

  tblm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .q_stat  (q_stat)
  );

  tblm_back #(
    .SUM_BITS   (SUM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop        (pop),
    .pop_op     (pop_op),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.overall_level <= tblm_pkg::LEVEL_MAX) &&
                  (out_result.low_level <= tblm_pkg::LEVEL_MAX) &&
                  (out_result.mid_level <= tblm_pkg::LEVEL_MAX) &&
                  (out_result.high_level <= tblm_pkg::LEVEL_MAX))
    else $error("level above full scale");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result.running) |->
      (out_result.overall_level == '0) && (out_result.low_level == '0) &&
      (out_result.mid_level == '0) && (out_result.high_level == '0))
    else $error("stopping report with nonzero level");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty) && !(push && q_stat.full))
    else $error("queue overrun or underrun");

endmodule
